// File: hw/rtl/lgps_pkg.sv
// Shared constants, register codes and types for the gait phase scheduler.
// Used by every module under hw/rtl; depends on nothing else.
package lgps_pkg;

   localparam int TICK_W      = 31;
   localparam int TPS_W       = 10;
   localparam int SEG_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int LEG_COUNT   = 4;
   localparam int LEG_IDX_W   = $clog2(LEG_COUNT);
   localparam int LEN_W       = TPS_W + SEG_W;
   localparam int FRAC_W      = 16;
   localparam int DVD_W       = LEN_W + FRAC_W;
   localparam int STEP_W      = $clog2(DVD_W + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ROW_W       = 4;
   localparam int SEG_OUT_W   = 4;
   localparam int MASK_W      = LEG_COUNT;
   localparam int PROG_W      = LEG_COUNT * FRAC_W;

   localparam int MAX_SEGMENTS_DEFAULT = 16;

   localparam logic [TPS_W-1:0]      TPS_RESET = TPS_W'(20);
   localparam logic [SEG_W-1:0]      SEG_RESET = SEG_W'(10);
   localparam logic [CSR_DATA_W-1:0] OFF_RESET = 32'h0005_0500;
   localparam logic [CSR_DATA_W-1:0] DUR_RESET = 32'h0505_0505;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SEGMENT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_COUNT     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_LEG_OFFSETS       = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_LEG_DURATIONS     = CSR_INDEX_W'(3);

   // Configuration after clamping, as the datapath uses it.
   typedef struct packed {
      logic [TPS_W-1:0]                 tps;
      logic [SEG_W-1:0]                 n;
      logic [LEG_COUNT-1:0][SEG_W-1:0]  off;
      logic [LEG_COUNT-1:0][SEG_W-1:0]  dur;
   } cfg_type;

   typedef struct packed {
      logic [LEN_W-1:0]  rem_init;
      logic [DVD_W-1:0]  dividend;
      logic [LEN_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quotient;
      logic [LEN_W-1:0]  remainder;
   } div_rsp_type;

   // One classified tick, handed from the front to the row emitter.
   typedef struct packed {
      logic [SEG_W-1:0]                  seg;
      logic [FRAC_W-1:0]                 phase;
      logic [LEG_COUNT-1:0][FRAC_W-1:0]  stance;
      logic [LEG_COUNT-1:0][FRAC_W-1:0]  swing;
   } rec_type;

endpackage

// File: hw/rtl/lgps_divider.sv
// Shared serial restoring divider, one quotient bit per clock.
// Depends on lgps_pkg for widths and request/response types.
module lgps_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  lgps_pkg::div_req_type  req,
   output lgps_pkg::div_rsp_type  rsp
);
   import lgps_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [LEN_W-1:0]  dsr_ff, dsr_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W:0]    trial;
   logic              take;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign take  = trial >= {1'b0, dsr_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         run_in = 1'b1;
         rem_in = req.rem_init;
         dvd_in = req.dividend;
         dsr_in = req.divisor;
         cnt_in = req.steps;
         quo_in = '0;
      end else if (run_ff) begin
         rem_in = take ? LEN_W'(trial - {1'b0, dsr_ff}) : trial[LEN_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[FRAC_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// File: hw/rtl/lgps_front.sv
// Front end: takes a tick, finds cycle position, segment, phase and per-leg progress.
// Depends on lgps_pkg and lgps_divider.
module lgps_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lgps_pkg::TICK_W-1:0]  tick_count,
   input  lgps_pkg::cfg_type            cfg,
   input  logic                         queue_full,
   output logic                         busy,
   output logic                         push,
   output lgps_pkg::rec_type            push_data
);
   import lgps_pkg::*;

   typedef enum logic [15:0] {
      F_IDLE     = 16'h0001,
      F_LEN      = 16'h0002,
      F_MOD_GO   = 16'h0004,
      F_MOD_WAIT = 16'h0008,
      F_SEG_GO   = 16'h0010,
      F_SEG_WAIT = 16'h0020,
      F_PH_GO    = 16'h0040,
      F_PH_WAIT  = 16'h0080,
      F_LEG_O    = 16'h0100,
      F_LEG_D    = 16'h0200,
      F_ST_GO    = 16'h0400,
      F_ST_WAIT  = 16'h0800,
      F_SW_PREP  = 16'h1000,
      F_SW_GO    = 16'h2000,
      F_SW_WAIT  = 16'h4000,
      F_PUSH     = 16'h8000
   } front_state_type;

   front_state_type                  state_ff, state_in;
   logic [TICK_W-1:0]                tick_ff, tick_in;
   logic [LEN_W-1:0]                 len_ff, len_in;
   logic [LEN_W-1:0]                 p_ff, p_in;
   logic [SEG_W-1:0]                 seg_ff, seg_in;
   logic [FRAC_W-1:0]                phase_ff, phase_in;
   logic [LEG_IDX_W-1:0]             leg_ff, leg_in;
   logic [LEN_W-1:0]                 ot_ff, ot_in;
   logic [LEN_W-1:0]                 dt_ff, dt_in;
   logic [LEN_W-1:0]                 so_ff, so_in;
   logic [LEN_W-1:0]                 w_ff, w_in;
   logic [LEG_COUNT-1:0][FRAC_W-1:0] stance_ff, stance_in;
   logic [LEG_COUNT-1:0][FRAC_W-1:0] swing_ff, swing_in;
   // Remembers whether the swing step launched a division.
   logic                             sw_div_ff, sw_div_in;

   logic [SEG_W-1:0]  mul_a;
   logic [LEN_W-1:0]  product;
   logic [LEN_W-1:0]  base;
   logic [LEN_W-1:0]  den;
   logic [LEN_W:0]    wrap_q;
   logic [LEN_W-1:0]  q;
   logic [LEN_W:0]    so_sum;
   logic              div_start;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   lgps_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // One small multiplier serves the cycle length and both per-leg tick counts.
   always_comb begin
      case (state_ff)
         F_LEN:   mul_a = cfg.n;
         F_LEG_O: mul_a = cfg.off[leg_ff];
         F_LEG_D: mul_a = cfg.dur[leg_ff];
         default: mul_a = '0;
      endcase
   end
   assign product = LEN_W'(mul_a) * LEN_W'(cfg.tps);

   // Distance from the stance or swing start back to the current position.
   assign base   = (state_ff == F_SW_GO) ? so_ff : ot_ff;
   assign den    = (state_ff == F_SW_GO) ? w_ff : dt_ff;
   assign wrap_q = {1'b0, p_ff} + {1'b0, len_ff} - {1'b0, base};
   assign q      = (p_ff >= base) ? LEN_W'(p_ff - base) : wrap_q[LEN_W-1:0];
   assign so_sum = {1'b0, ot_ff} + {1'b0, dt_ff};

   always_comb begin
      state_in  = state_ff;
      tick_in   = tick_ff;
      len_in    = len_ff;
      p_in      = p_ff;
      seg_in    = seg_ff;
      phase_in  = phase_ff;
      leg_in    = leg_ff;
      ot_in     = ot_ff;
      dt_in     = dt_ff;
      so_in     = so_ff;
      w_in      = w_ff;
      stance_in = stance_ff;
      swing_in  = swing_ff;
      div_start = 1'b0;
      div_req   = '0;
      push      = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               tick_in  = tick_count;
               leg_in   = '0;
               state_in = F_LEN;
            end
         end
         F_LEN: begin
            len_in   = product;
            state_in = F_MOD_GO;
         end
         F_MOD_GO: begin
            div_start        = 1'b1;
            div_req.rem_init = '0;
            div_req.dividend = DVD_W'(tick_ff);
            div_req.divisor  = len_ff;
            div_req.steps    = STEP_W'(TICK_W);
            state_in         = F_MOD_WAIT;
         end
         F_MOD_WAIT: begin
            if (div_rsp.done) begin
               p_in     = div_rsp.remainder;
               state_in = F_SEG_GO;
            end
         end
         F_SEG_GO: begin
            div_start        = 1'b1;
            div_req.rem_init = '0;
            div_req.dividend = {p_ff, FRAC_W'(0)};
            div_req.divisor  = LEN_W'(cfg.tps);
            div_req.steps    = STEP_W'(LEN_W);
            state_in         = F_SEG_WAIT;
         end
         F_SEG_WAIT: begin
            if (div_rsp.done) begin
               seg_in   = div_rsp.quotient[SEG_W-1:0];
               state_in = F_PH_GO;
            end
         end
         F_PH_GO: begin
            div_start        = 1'b1;
            div_req.rem_init = p_ff;
            div_req.dividend = '0;
            div_req.divisor  = len_ff;
            div_req.steps    = STEP_W'(FRAC_W);
            state_in         = F_PH_WAIT;
         end
         F_PH_WAIT: begin
            if (div_rsp.done) begin
               phase_in = div_rsp.quotient;
               state_in = F_LEG_O;
            end
         end
         F_LEG_O: begin
            ot_in    = product;
            state_in = F_LEG_D;
         end
         F_LEG_D: begin
            dt_in    = product;
            state_in = F_ST_GO;
         end
         F_ST_GO: begin
            // An empty stance or a position past its end reads as zero; exactly at
            // the end the progress saturates just below one.
            if (den == '0 || q > den) begin
               stance_in[leg_ff] = '0;
               state_in          = F_SW_PREP;
            end else if (q == den) begin
               stance_in[leg_ff] = '1;
               state_in          = F_SW_PREP;
            end else begin
               div_start        = 1'b1;
               div_req.rem_init = q;
               div_req.dividend = '0;
               div_req.divisor  = den;
               div_req.steps    = STEP_W'(FRAC_W);
               state_in         = F_ST_WAIT;
            end
         end
         F_ST_WAIT: begin
            if (div_rsp.done) begin
               stance_in[leg_ff] = div_rsp.quotient;
               state_in          = F_SW_PREP;
            end
         end
         F_SW_PREP: begin
            so_in    = (so_sum > {1'b0, len_ff}) ? LEN_W'(so_sum - {1'b0, len_ff})
                                                 : so_sum[LEN_W-1:0];
            w_in     = len_ff - dt_ff;
            state_in = F_SW_GO;
         end
         F_SW_GO: begin
            if (den == '0 || q > den) begin
               swing_in[leg_ff] = '0;
               state_in         = F_SW_WAIT;
            end else if (q == den) begin
               swing_in[leg_ff] = '1;
               state_in         = F_SW_WAIT;
            end else begin
               div_start        = 1'b1;
               div_req.rem_init = q;
               div_req.dividend = '0;
               div_req.divisor  = den;
               div_req.steps    = STEP_W'(FRAC_W);
               state_in         = F_SW_WAIT;
            end
         end
         F_SW_WAIT: begin
            // Entered either with the swing value already set or with a division
            // running; only the running case waits for the divider.
            if (div_rsp.done || !sw_div_ff) begin
               if (div_rsp.done) begin
                  swing_in[leg_ff] = div_rsp.quotient;
               end
               if (leg_ff == LEG_IDX_W'(LEG_COUNT - 1)) begin
                  state_in = F_PUSH;
               end else begin
                  leg_in   = leg_ff + 1'b1;
                  state_in = F_LEG_O;
               end
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign sw_div_in = (state_ff == F_SW_GO) ? div_start : sw_div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         sw_div_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sw_div_ff <= sw_div_in;
      end
      tick_ff   <= tick_in;
      len_ff    <= len_in;
      p_ff      <= p_in;
      seg_ff    <= seg_in;
      phase_ff  <= phase_in;
      leg_ff    <= leg_in;
      ot_ff     <= ot_in;
      dt_ff     <= dt_in;
      so_ff     <= so_in;
      w_ff      <= w_in;
      stance_ff <= stance_in;
      swing_ff  <= swing_in;
   end

   assign busy             = (state_ff != F_IDLE);
   assign push_data.seg    = seg_ff;
   assign push_data.phase  = phase_ff;
   assign push_data.stance = stance_ff;
   assign push_data.swing  = swing_ff;

endmodule

// File: hw/rtl/lgps_queue.sv
// Two-entry queue of classified ticks between the front end and the row emitter.
// Depends on lgps_pkg for the entry type and depth.
module lgps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lgps_pkg::rec_type  push_data,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output lgps_pkg::rec_type  head
);
   import lgps_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/lgps_back.sv
// Row emitter: one lookahead row per clock, with that future segment's contact mask.
// Depends on lgps_pkg for the entry and configuration types.
module lgps_back (
   input  logic                            clock,
   input  logic                            reset,
   input  lgps_pkg::cfg_type               cfg,
   input  logic                            queue_empty,
   input  lgps_pkg::rec_type               head,
   output logic                            pop,
   output logic                            rsp_strobe,
   output logic [lgps_pkg::ROW_W-1:0]      rsp_horizon_row,
   output logic [lgps_pkg::MASK_W-1:0]     rsp_contact_mask,
   output logic                            rsp_last_row,
   output logic [lgps_pkg::SEG_OUT_W-1:0]  rsp_segment_index,
   output logic [lgps_pkg::FRAC_W-1:0]     rsp_cycle_phase,
   output logic [lgps_pkg::PROG_W-1:0]     rsp_stance_progress,
   output logic [lgps_pkg::PROG_W-1:0]     rsp_swing_progress
);
   import lgps_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_EMIT = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   rec_type           cur_ff, cur_in;
   logic [SEG_W-1:0]  row_ff, row_in;
   logic [SEG_W-1:0]  it_ff, it_in;
   logic              strobe_ff, strobe_in;
   logic [ROW_W-1:0]     row_out_ff, row_out_in;
   logic [MASK_W-1:0]    mask_out_ff, mask_out_in;
   logic                 last_out_ff, last_out_in;
   logic [SEG_OUT_W-1:0] seg_out_ff, seg_out_in;
   logic [FRAC_W-1:0]    phase_out_ff, phase_out_in;
   logic [PROG_W-1:0]    stance_out_ff, stance_out_in;
   logic [PROG_W-1:0]    swing_out_ff, swing_out_in;

   logic [SEG_W-1:0]  first_it;
   logic [SEG_W-1:0]  next_it;
   logic              last;
   logic [SEG_W:0]    prog [LEG_COUNT];
   logic [MASK_W-1:0] mask;

   assign first_it = (head.seg + 1'b1 == cfg.n) ? '0 : head.seg + 1'b1;
   assign next_it  = (it_ff + 1'b1 == cfg.n) ? '0 : it_ff + 1'b1;
   assign last     = (row_ff == cfg.n - 1'b1);

   // A leg stands in a segment when the segment lies within its stance window,
   // counted forward from its offset around the cycle.
   always_comb begin
      for (int l = 0; l < LEG_COUNT; l++) begin
         if (it_ff >= cfg.off[l]) begin
            prog[l] = {1'b0, it_ff} - {1'b0, cfg.off[l]};
         end else begin
            prog[l] = {1'b0, it_ff} + {1'b0, cfg.n} - {1'b0, cfg.off[l]};
         end
         mask[l] = prog[l] < {1'b0, cfg.dur[l]};
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      row_in        = row_ff;
      it_in         = it_ff;
      pop           = 1'b0;
      strobe_in     = 1'b0;
      row_out_in    = row_out_ff;
      mask_out_in   = mask_out_ff;
      last_out_in   = last_out_ff;
      seg_out_in    = seg_out_ff;
      phase_out_in  = phase_out_ff;
      stance_out_in = stance_out_ff;
      swing_out_in  = swing_out_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               cur_in   = head;
               row_in   = '0;
               it_in    = first_it;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            strobe_in     = 1'b1;
            row_out_in    = ROW_W'(row_ff);
            mask_out_in   = mask;
            last_out_in   = last;
            seg_out_in    = SEG_OUT_W'(cur_ff.seg);
            phase_out_in  = cur_ff.phase;
            stance_out_in = cur_ff.stance;
            swing_out_in  = cur_ff.swing;
            if (last) begin
               state_in = B_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
               it_in  = next_it;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      cur_ff        <= cur_in;
      row_ff        <= row_in;
      it_ff         <= it_in;
      row_out_ff    <= row_out_in;
      mask_out_ff   <= mask_out_in;
      last_out_ff   <= last_out_in;
      seg_out_ff    <= seg_out_in;
      phase_out_ff  <= phase_out_in;
      stance_out_ff <= stance_out_in;
      swing_out_ff  <= swing_out_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_horizon_row     = row_out_ff;
   assign rsp_contact_mask    = mask_out_ff;
   assign rsp_last_row        = last_out_ff;
   assign rsp_segment_index   = seg_out_ff;
   assign rsp_cycle_phase     = phase_out_ff;
   assign rsp_stance_progress = stance_out_ff;
   assign rsp_swing_progress  = swing_out_ff;

endmodule

// File: hw/rtl/legged_gait_phase_scheduler.sv
// Top level of the four-leg gait phase scheduler: configuration registers,
// front end, queue and row emitter. Depends on lgps_pkg and all lgps_* modules.
//
// Pulse start while busy is low to hand in one control tick count; busy rises at the
// next edge and stays high while the front end works on that tick (longer only if
// the queue is full), the bulk of it spent in one shared serial divider that yields
// one quotient bit per clock (a 31-bit modulo, a segment divide, the cycle phase and
// up to eight leg progress fractions). Each tick then produces one result beat per
// gait segment, on consecutive clocks, each marked by rsp_strobe for exactly one
// clock; the receiver cannot hold beats off and must take every one of them. When
// the row emitter is idle, the first beat of a tick comes out after busy falls, once
// the record has passed the queue, the emitter's idle state and its output registers,
// and rsp_last_row marks the final beat. A two-entry queue sits between the front end
// and the row emitter, so the next tick may be handed in while the previous one's
// rows are still going out. Configuration registers are written through the csr_
// port, one per clock, and must only be changed while no tick is in flight.
module legged_gait_phase_scheduler #(
   parameter int MAX_SEGMENTS = lgps_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lgps_pkg::TICK_W-1:0]       req_tick_count,
   output logic                              rsp_strobe,
   output logic [lgps_pkg::ROW_W-1:0]        rsp_horizon_row,
   output logic [lgps_pkg::MASK_W-1:0]       rsp_contact_mask,
   output logic                              rsp_last_row,
   output logic [lgps_pkg::SEG_OUT_W-1:0]    rsp_segment_index,
   output logic [lgps_pkg::FRAC_W-1:0]       rsp_cycle_phase,
   output logic [lgps_pkg::PROG_W-1:0]       rsp_stance_progress,
   output logic [lgps_pkg::PROG_W-1:0]       rsp_swing_progress,
   input  logic                              csr_write_enable,
   input  logic [lgps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lgps_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import lgps_pkg::*;

   logic [TPS_W-1:0]      tps_ff, tps_in;
   logic [SEG_W-1:0]      nseg_ff, nseg_in;
   logic [CSR_DATA_W-1:0] off_ff, off_in;
   logic [CSR_DATA_W-1:0] dur_ff, dur_in;
   cfg_type               cfg_ff, cfg_in;
   logic [SEG_W-1:0]      n_eff;
   logic [BYTE_W-1:0]     off_byte [LEG_COUNT];
   logic [BYTE_W-1:0]     dur_byte [LEG_COUNT];

   logic     front_busy;
   logic     accept;
   logic     push;
   rec_type  push_data;
   logic     queue_full;
   logic     queue_empty;
   logic     pop;
   rec_type  head;

   // Register writes. Unknown indexes leave every register unchanged.
   always_comb begin
      tps_in  = tps_ff;
      nseg_in = nseg_ff;
      off_in  = off_ff;
      dur_in  = dur_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TICKS_PER_SEGMENT: tps_in  = csr_write_data[TPS_W-1:0];
            CSR_SEGMENT_COUNT:     nseg_in = csr_write_data[SEG_W-1:0];
            CSR_LEG_OFFSETS:       off_in  = csr_write_data;
            CSR_LEG_DURATIONS:     dur_in  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Clamped configuration. A zero tick count per segment counts as one, the segment
   // count is held between one and the maximum, offsets are held below the segment
   // count and durations at or below it. The result is registered in cfg_ff, behind
   // the configuration registers, so the datapath sees a write only once both hold it.
   always_comb begin
      if (nseg_ff == '0) begin
         n_eff = SEG_W'(1);
      end else if (32'(nseg_ff) > MAX_SEGMENTS) begin
         n_eff = SEG_W'(MAX_SEGMENTS);
      end else begin
         n_eff = nseg_ff;
      end
      cfg_in.tps = (tps_ff == '0) ? TPS_W'(1) : tps_ff;
      cfg_in.n   = n_eff;
      for (int l = 0; l < LEG_COUNT; l++) begin
         off_byte[l] = off_ff[l*BYTE_W +: BYTE_W];
         dur_byte[l] = dur_ff[l*BYTE_W +: BYTE_W];
         if (off_byte[l] > BYTE_W'(n_eff - 1'b1)) begin
            cfg_in.off[l] = n_eff - 1'b1;
         end else begin
            cfg_in.off[l] = off_byte[l][SEG_W-1:0];
         end
         if (dur_byte[l] > BYTE_W'(n_eff)) begin
            cfg_in.dur[l] = n_eff;
         end else begin
            cfg_in.dur[l] = dur_byte[l][SEG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff  <= TPS_RESET;
         nseg_ff <= SEG_RESET;
         off_ff  <= OFF_RESET;
         dur_ff  <= DUR_RESET;
      end else begin
         tps_ff  <= tps_in;
         nseg_ff <= nseg_in;
         off_ff  <= off_in;
         dur_ff  <= dur_in;
      end
      cfg_ff <= cfg_in;
   end

   assign busy   = front_busy;
   assign accept = start && !front_busy;

   lgps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .tick_count (req_tick_count),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .busy       (front_busy),
      .push       (push),
      .push_data  (push_data)
   );

   lgps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   lgps_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .queue_empty         (queue_empty),
      .head                (head),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_horizon_row     (rsp_horizon_row),
      .rsp_contact_mask    (rsp_contact_mask),
      .rsp_last_row        (rsp_last_row),
      .rsp_segment_index   (rsp_segment_index),
      .rsp_cycle_phase     (rsp_cycle_phase),
      .rsp_stance_progress (rsp_stance_progress),
      .rsp_swing_progress  (rsp_swing_progress)
   );

endmodule

// File: tb/legged_gait_phase_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for legged_gait_phase_scheduler. It predicts every horizon row
// beat of each tick from a shadow copy of the registers and checks it field by field.
// Depends on lgps_pkg and the scheduler RTL; needs nothing else.
module legged_gait_phase_scheduler_tb;
   import lgps_pkg::*;

   // Watchdog limit on quiet cycles, well above the time a tick spends in the front end
   // plus the sender's random gap. Nothing should ever stay quiet for anywhere near this long.
   localparam int IDLE_LIMIT    = 4000;
   // Pause after the last row beat before touching the registers, and at the end.
   localparam int SETTLE_CYCLES = 16;
   localparam int SEG_LIMIT     = MAX_SEGMENTS_DEFAULT;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_TICKS   = 38;

   // One horizon row beat, laid out as the result ports present it.
   typedef struct packed {
      logic [ROW_W-1:0]     horizon_row;
      logic [MASK_W-1:0]    contact_mask;
      logic                 last_row;
      logic [SEG_OUT_W-1:0] segment_index;
      logic [FRAC_W-1:0]    cycle_phase;
      logic [PROG_W-1:0]    stance_progress;
      logic [PROG_W-1:0]    swing_progress;
   } gait_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [TICK_W-1:0]       req_tick_count = '0;
   logic                    rsp_strobe;
   logic [ROW_W-1:0]        rsp_horizon_row;
   logic [MASK_W-1:0]       rsp_contact_mask;
   logic                    rsp_last_row;
   logic [SEG_OUT_W-1:0]    rsp_segment_index;
   logic [FRAC_W-1:0]       rsp_cycle_phase;
   logic [PROG_W-1:0]       rsp_stance_progress;
   logic [PROG_W-1:0]       rsp_swing_progress;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_TICKS_PER_SEGMENT;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   // Ticks waiting to be handed in, and row beats the scheduler still owes us.
   logic [TICK_W-1:0] pending_ticks[$];
   gait_row_type      rows_due[$];

   // Shadow copy of the configuration registers, updated from the write port itself.
   logic [TPS_W-1:0]      shadow_tps  = TPS_RESET;
   logic [SEG_W-1:0]      shadow_segs = SEG_RESET;
   logic [CSR_DATA_W-1:0] shadow_offs = OFF_RESET;
   logic [CSR_DATA_W-1:0] shadow_durs = DUR_RESET;

   logic tick_accepted = 1'b0;
   int   idle_left     = 0;
   bit   no_idle       = 1'b0;
   int   error_count   = 0;
   int   quiet_cycles  = 0;

   legged_gait_phase_scheduler DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_tick_count      (req_tick_count),
      .rsp_strobe          (rsp_strobe),
      .rsp_horizon_row     (rsp_horizon_row),
      .rsp_contact_mask    (rsp_contact_mask),
      .rsp_last_row        (rsp_last_row),
      .rsp_segment_index   (rsp_segment_index),
      .rsp_cycle_phase     (rsp_cycle_phase),
      .rsp_stance_progress (rsp_stance_progress),
      .rsp_swing_progress  (rsp_swing_progress),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Q0.16 fraction num/den. A zero-length span or a position past the end of the span
   // gives 0; a position exactly at the end would be 1.0 and saturates to all ones.
   function automatic logic [FRAC_W-1:0] q16_fraction(input logic [63:0] num,
                                                      input logic [63:0] den);
      logic [63:0] ratio;
      if (den == 0 || num > den) return '0;
      ratio = (num << FRAC_W) / den;
      return (ratio > 64'hFFFF) ? {FRAC_W{1'b1}} : ratio[FRAC_W-1:0];
   endfunction

   // Works out every horizon row for one tick under the shadow configuration and
   // queues them in emission order.
   function automatic void predict_horizon(input logic [TICK_W-1:0] tick);
      logic [63:0] tps, segs, cyc_len, pos, seg, phase;
      logic [63:0] off, dur, base, q, ahead, into;
      logic [63:0] leg_off[LEG_COUNT];
      logic [63:0] leg_dur[LEG_COUNT];
      logic [PROG_W-1:0] stance, swing;
      logic [MASK_W-1:0] mask;
      gait_row_type row;
      int i, j;

      // Zero ticks per segment counts as one; the segment count is clamped to 1..16.
      tps = (shadow_tps == 0) ? 64'd1 : 64'(shadow_tps);
      segs = 64'(shadow_segs);
      if (segs == 0) segs = 1;
      if (segs > SEG_LIMIT) segs = SEG_LIMIT;
      cyc_len = tps * segs;
      pos   = 64'(tick) % cyc_len;
      seg   = pos / tps;
      phase = (pos << FRAC_W) / cyc_len;

      stance = '0;
      swing  = '0;
      for (j = 0; j < LEG_COUNT; j++) begin
         off = 64'(shadow_offs[BYTE_W*j +: BYTE_W]);
         dur = 64'(shadow_durs[BYTE_W*j +: BYTE_W]);
         // Offsets past the last segment and durations past a whole cycle saturate.
         if (off > segs - 1) off = segs - 1;
         if (dur > segs) dur = segs;
         leg_off[j] = off;
         leg_dur[j] = dur;

         // Stance runs from the offset for dur segments, counted modulo the cycle.
         base = off * tps;
         q = (pos >= base) ? pos - base : pos + cyc_len - base;
         stance[FRAC_W*j +: FRAC_W] = q16_fraction(q, dur * tps);

         // Swing starts where stance ends and fills the rest of the cycle.
         base = (off + dur) * tps;
         if (base > cyc_len) base -= cyc_len;
         q = (pos >= base) ? pos - base : pos + cyc_len - base;
         swing[FRAC_W*j +: FRAC_W] = q16_fraction(q, cyc_len - dur * tps);
      end

      // Row i looks at the segment i+1 ahead of the current one.
      for (i = 0; i < segs; i++) begin
         ahead = (64'(i) + seg + 1) % segs;
         mask = '0;
         for (j = 0; j < LEG_COUNT; j++) begin
            into = (ahead >= leg_off[j]) ? ahead - leg_off[j] : ahead + segs - leg_off[j];
            if (into < leg_dur[j]) mask[j] = 1'b1;
         end
         row.horizon_row     = ROW_W'(i);
         row.contact_mask    = mask;
         row.last_row        = (i == segs - 1);
         row.segment_index   = SEG_OUT_W'(seg);
         row.cycle_phase     = phase[FRAC_W-1:0];
         row.stance_progress = stance;
         row.swing_progress  = swing;
         rows_due.push_back(row);
      end
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   // Driver. Changes the request side at the falling edge. A beat that has not been
   // taken yet is simply held; once taken, the next tick goes out after its drawn gap.
   // Each signal gets one assignment per edge, so back-to-back beats keep start high.
   always @(negedge clock) begin
      logic [TICK_W-1:0] next_tick;
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (start && !tick_accepted) begin
         // Still waiting for the scheduler to take the current beat.
      end else if (idle_left > 0) begin
         start     <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (pending_ticks.size() != 0) begin
         next_tick      = pending_ticks.pop_front();
         start          <= 1'b1;
         req_tick_count <= next_tick;
         idle_left      <= no_idle ? 0 : $urandom_range(0, 10);
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor. Everything is sampled at the rising edge, where the handshake happens.
   // Register writes land in the shadow copy, accepted ticks are predicted, and each
   // strobed row beat is checked against the oldest prediction.
   always @(posedge clock) begin
      gait_row_type want;
      if (reset) begin
         shadow_tps    <= TPS_RESET;
         shadow_segs   <= SEG_RESET;
         shadow_offs   <= OFF_RESET;
         shadow_durs   <= DUR_RESET;
         tick_accepted <= 1'b0;
         quiet_cycles  <= 0;
      end else begin
         tick_accepted <= start && !busy;

         if (csr_write_enable) begin
            case (csr_index)
               CSR_TICKS_PER_SEGMENT: shadow_tps  <= csr_write_data[TPS_W-1:0];
               CSR_SEGMENT_COUNT:     shadow_segs <= csr_write_data[SEG_W-1:0];
               CSR_LEG_OFFSETS:       shadow_offs <= csr_write_data;
               CSR_LEG_DURATIONS:     shadow_durs <= csr_write_data;
               default: ;  // Writes to unused indexes are dropped.
            endcase
         end

         // Check the outgoing beat before queueing rows of a tick taken on this edge.
         if (rsp_strobe) begin
            if (rows_due.size() == 0) begin
               $error("row beat with nothing expected: row 0x%0h mask 0x%0h",
                      rsp_horizon_row, rsp_contact_mask);
               error_count++;
            end else begin
               want = rows_due.pop_front();
               check_field("horizon_row", want.horizon_row, rsp_horizon_row);
               check_field("contact_mask", want.contact_mask, rsp_contact_mask);
               check_field("last_row", want.last_row, rsp_last_row);
               check_field("segment_index", want.segment_index, rsp_segment_index);
               check_field("cycle_phase", want.cycle_phase, rsp_cycle_phase);
               check_field("stance_progress", want.stance_progress, rsp_stance_progress);
               check_field("swing_progress", want.swing_progress, rsp_swing_progress);
            end
         end

         if (start && !busy) predict_horizon(req_tick_count);

         // Watchdog on cycles in which no beat of any kind moves.
         if ((start && !busy) || rsp_strobe || csr_write_enable) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Blocks until every queued tick is taken and every row beat has come out, then
   // lets the row emitter wind down before the registers may change.
   task automatic drain_rows();
      @(posedge clock);
      while (pending_ticks.size() != 0 || start || rows_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Stimulus sequencer. Directed phases first, then random configurations each
   // followed by a batch of ticks. The registers only change while nothing is in flight.
   initial begin
      int unsigned cfg_tps, cfg_segs, tps_eff, segs_eff, len_eff;
      logic [CSR_DATA_W-1:0] cfg_offs, cfg_durs;
      logic [TICK_W-1:0] run_tick;
      int b, k, ph;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: 20 ticks x 10 segments. Cycle start and end, segment
      // edges, a stance that ends exactly on a tick (saturates), and the largest count.
      pending_ticks.push_back(TICK_W'(0));
      pending_ticks.push_back(TICK_W'(1));
      pending_ticks.push_back(TICK_W'(19));
      pending_ticks.push_back(TICK_W'(20));
      pending_ticks.push_back(TICK_W'(100));
      pending_ticks.push_back(TICK_W'(199));
      pending_ticks.push_back(TICK_W'(200));
      pending_ticks.push_back(TICK_W'(32'h7FFF_FFFF));
      pending_ticks.push_back(TICK_W'(32'h5555_5555));
      drain_rows();

      // Zero ticks per segment and zero segments, both treated as one. Offsets all
      // saturate; legs have zero stance, full stance (zero swing) and oversize duration.
      // Writes to unused indexes must leave the real registers alone.
      write_csr(CSR_TICKS_PER_SEGMENT, 32'hFFFF_FC00);
      write_csr(CSR_SEGMENT_COUNT, 32'hFFFF_FFE0);
      write_csr(CSR_LEG_OFFSETS, 32'hFFFF_FFFF);
      write_csr(CSR_LEG_DURATIONS, 32'h00FF_0100);
      write_csr(CSR_INDEX_W'(4), 32'h0000_0007);
      write_csr(CSR_INDEX_W'(7), 32'hFFFF_FFFF);
      pending_ticks.push_back(TICK_W'(0));
      pending_ticks.push_back(TICK_W'(32'h2AAA_AAAA));
      drain_rows();

      // Longest segments and a segment count above the maximum, which saturates to 16.
      write_csr(CSR_TICKS_PER_SEGMENT, 32'd1023);
      write_csr(CSR_SEGMENT_COUNT, 32'd31);
      write_csr(CSR_LEG_OFFSETS, 32'h0FFF_1000);
      write_csr(CSR_LEG_DURATIONS, 32'h1020_0001);
      pending_ticks.push_back(TICK_W'(0));
      pending_ticks.push_back(TICK_W'(1022));
      pending_ticks.push_back(TICK_W'(1023));
      pending_ticks.push_back(TICK_W'(16367));
      pending_ticks.push_back(TICK_W'(16368));
      pending_ticks.push_back(TICK_W'(32'h7FFF_FFFF));
      drain_rows();

      // One tick per segment, 16 segments; the last leg's stance wraps past cycle end.
      write_csr(CSR_TICKS_PER_SEGMENT, 32'd1);
      write_csr(CSR_SEGMENT_COUNT, 32'd16);
      write_csr(CSR_LEG_OFFSETS, 32'h0C08_0400);
      write_csr(CSR_LEG_DURATIONS, 32'h0C04_0808);
      pending_ticks.push_back(TICK_W'(0));
      pending_ticks.push_back(TICK_W'(5));
      pending_ticks.push_back(TICK_W'(15));
      pending_ticks.push_back(TICK_W'(32'h7FFF_FFF0));
      drain_rows();

      // Random configurations. Most offsets and durations are in range so the masks
      // stay interesting; some bytes are wild to keep exercising saturation.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 7))
            0:       cfg_tps = 0;
            1:       cfg_tps = 1;
            2:       cfg_tps = 1023;
            default: cfg_tps = $urandom_range(1, 1023);
         endcase
         cfg_segs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(1, 16);
         tps_eff  = (cfg_tps == 0) ? 1 : cfg_tps;
         segs_eff = (cfg_segs == 0) ? 1 : ((cfg_segs > SEG_LIMIT) ? SEG_LIMIT : cfg_segs);
         len_eff  = tps_eff * segs_eff;
         for (b = 0; b < LEG_COUNT; b++) begin
            cfg_offs[BYTE_W*b +: BYTE_W] = BYTE_W'(($urandom_range(0, 4) == 0)
               ? $urandom_range(0, 255) : $urandom_range(0, segs_eff - 1));
            cfg_durs[BYTE_W*b +: BYTE_W] = BYTE_W'(($urandom_range(0, 4) == 0)
               ? $urandom_range(0, 255) : $urandom_range(0, segs_eff));
         end
         // Upper data bits of the narrow registers carry junk that must be ignored.
         write_csr(CSR_TICKS_PER_SEGMENT, ($urandom & 32'hFFFF_FC00) | cfg_tps);
         write_csr(CSR_SEGMENT_COUNT, ($urandom & 32'hFFFF_FFE0) | cfg_segs);
         write_csr(CSR_LEG_OFFSETS, cfg_offs);
         write_csr(CSR_LEG_DURATIONS, cfg_durs);
         if ($urandom_range(0, 2) == 0)
            write_csr(CSR_INDEX_W'($urandom_range(4, 7)), $urandom);
         no_idle = ($urandom_range(0, 3) == 0);

         // In part a running tick counter, as a control loop would send, mixed with
         // random counts, segment edges and counts near the top of the range.
         run_tick = TICK_W'($urandom);
         for (k = 0; k < PHASE_TICKS; k++) begin
            case ($urandom_range(0, 6))
               0: run_tick = TICK_W'($urandom);
               1: run_tick = TICK_W'($urandom_range(0, 4 * len_eff));
               2: run_tick = TICK_W'($urandom_range(1, 50000) * tps_eff
                                     - $urandom_range(0, 1));
               3: run_tick = TICK_W'(32'h7FFF_FFFF - $urandom_range(0, 2 * len_eff));
               default: run_tick = run_tick + 1'b1;
            endcase
            pending_ticks.push_back(run_tick);
         end
         drain_rows();
      end

      no_idle = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && rows_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
